### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker of the list store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low, fixed message.
`define ILS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("list store assertion failed");

// Clocked assertion, disabled while reset is held low, caller message.
`define ILS_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

`endif

### rtl/core/ils_pkg.sv
// Package of types and constants for the indexed list store.
package ils_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Port field widths.
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 2;

    // Internal widths.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [FUNC_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic                  ins;
        logic                  ers;
        logic [IDX_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_ctl;

endpackage

### rtl/core/indexed_list_store.sv
// Top level of the indexed list store: request decode, count and result register.
//
// Ordered list of up to CAPACITY words held in a row of cells that shift in
// parallel. Each request carries an operation: append a word at the end,
// insert a word at an index (later entries move up one cell), erase the entry
// at an index (later entries move down one cell), or read the entry at an
// index. Insert at an index equal to the current length behaves as append.
// Every request yields exactly one result with the read word (zero unless a
// read succeeds), the length after the request and a status: ok, index out of
// range, or list full. A failing request leaves the list unchanged; for insert
// the range check wins over the full check. Throughput is one request per
// clock: the whole row of cells shifts in the cycle the request is accepted,
// and the result appears in the output register on the next cycle. The only
// thing that holds a request back is a result still waiting downstream, so
// o_in_stall follows i_out_stall while a result is held. Cell contents are
// not cleared by reset; only entries below the length are ever returned.
module indexed_list_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ils_pkg::FUNC_W-1:0]   i_in_func,
    input  logic [ils_pkg::VALUE_W-1:0]  i_in_value,
    input  logic [ils_pkg::POS_W-1:0]    i_in_position,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ils_pkg::VALUE_W-1:0]  o_out_read_data,
    output logic [ils_pkg::LEN_W-1:0]    o_out_length,
    output logic [ils_pkg::STATUS_W-1:0] o_out_status
);
    import ils_pkg::*;

    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_read_data;
    logic [STATUS_W-1:0]   r_status;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic                  accept;
    t_op                   op;
    logic [CMP_W-1:0]      cmp_pos;
    logic [CMP_W-1:0]      cmp_cnt;
    logic                  full;
    logic                  is_app;
    t_status               status;
    logic                  rd_ok;
    t_cell_ctl             ctl;
    logic [DATA_WIDTH-1:0] rd_word;

    // Take a request unless a finished result is held by the consumer.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign op      = t_op'(i_in_func);
    assign cmp_pos = CMP_W'(i_in_position);
    assign cmp_cnt = CMP_W'(r_count);
    assign full    = (r_count == CNT_W'(CAPACITY));
    // Insert at the end of the list is an append.
    assign is_app  = (op == OP_APPEND) || ((op == OP_INSERT) && (cmp_pos == cmp_cnt));

    // Decode the request into a status, a new count and the row control.
    always_comb begin
        status    = ST_OK;
        n_count   = r_count;
        rd_ok     = 1'b0;
        ctl.ins   = 1'b0;
        ctl.ers   = 1'b0;
        ctl.pos   = IDX_W'(i_in_position);
        ctl.value = i_in_value[DATA_WIDTH-1:0];
        priority if (is_app) begin
            ctl.pos = r_count[IDX_W-1:0];
            if (full) begin
                status = ST_FULL;
            end else begin
                ctl.ins = accept;
                n_count = r_count + 1'b1;
            end
        end else if (op == OP_INSERT) begin
            if (cmp_pos > cmp_cnt) begin
                status = ST_RANGE;
            end else if (full) begin
                status = ST_FULL;
            end else begin
                ctl.ins = accept;
                n_count = r_count + 1'b1;
            end
        end else if (op == OP_ERASE) begin
            if (cmp_pos >= cmp_cnt) begin
                status = ST_RANGE;
            end else begin
                ctl.ers = accept;
                n_count = r_count - 1'b1;
            end
        end else begin
            if (cmp_pos >= cmp_cnt) begin
                status = ST_RANGE;
            end else begin
                rd_ok = 1'b1;
            end
        end
    end

    ils_row u_row (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_rd_idx  (IDX_W'(i_in_position)),
        .o_rd_data (rd_word)
    );

    // Advance the count only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // Load a result on accept; drop it once the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result payload until the next accepted request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data <= rd_ok ? VALUE_W'(rd_word) : '0;
            r_status    <= status;
        end
    end

    // The count register already reflects the latest accepted request.
    assign o_out_valid     = r_out_valid;
    assign o_out_read_data = r_read_data;
    assign o_out_length    = LEN_W'(r_count);
    assign o_out_status    = r_status;

endmodule

### rtl/core/ils_cell.sv
// One storage cell of the list row: holds, loads or takes a neighbor's word.
module ils_cell (
    input  logic                          i_clk,
    input  logic [ils_pkg::IDX_W-1:0]      i_index,
    input  ils_pkg::t_cell_ctl             i_ctl,
    input  logic [ils_pkg::DATA_WIDTH-1:0] i_left,
    input  logic [ils_pkg::DATA_WIDTH-1:0] i_right,
    output logic [ils_pkg::DATA_WIDTH-1:0] o_data
);
    import ils_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        priority if (i_ctl.ins) begin
            if (i_index == i_ctl.pos) begin
                n_data = i_ctl.value;
            end else if (i_index > i_ctl.pos) begin
                n_data = i_left;
            end
        end else if (i_ctl.ers) begin
            if (i_index >= i_ctl.pos) begin
                n_data = i_right;
            end
        end else begin
            // Hold the word when the row is idle.
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### rtl/core/ils_row.sv
// Row of list cells with neighbor links and an indexed read port.
module ils_row (
    input  logic                          i_clk,
    input  ils_pkg::t_cell_ctl             i_ctl,
    input  logic [ils_pkg::IDX_W-1:0]      i_rd_idx,
    output logic [ils_pkg::DATA_WIDTH-1:0] o_rd_data
);
    import ils_pkg::*;

    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (k == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_q[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_q[k+1];
        end

        ils_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(k)),
            .i_ctl   (i_ctl),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_q[k])
        );
    end

    assign o_rd_data = cell_q[i_rd_idx];

endmodule

### rtl/core/ils_checker.sv
// Port-level checker for the indexed list store, bound to the top level.
`include "assert_macros.svh"

module ils_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [ils_pkg::FUNC_W-1:0]   i_in_func,
    input logic [ils_pkg::VALUE_W-1:0]  i_in_value,
    input logic [ils_pkg::POS_W-1:0]    i_in_position,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [ils_pkg::VALUE_W-1:0]  o_out_read_data,
    input logic [ils_pkg::LEN_W-1:0]    o_out_length,
    input logic [ils_pkg::STATUS_W-1:0] o_out_status
);
    import ils_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    `ILS_ASSERT_MSG(a_result_follows, i_clk, i_rst_n, in_acc |=> o_out_valid, "request lost")
    `ILS_ASSERT(a_len_bound, i_clk, i_rst_n, o_out_valid |-> (o_out_length <= LEN_W'(CAPACITY)))
    `ILS_ASSERT_MSG(a_full_len, i_clk, i_rst_n, (o_out_valid && (o_out_status == ST_FULL)) |-> (o_out_length == LEN_W'(CAPACITY)), "full status below capacity")
    `ILS_ASSERT(a_rdata_ok, i_clk, i_rst_n, (o_out_valid && (o_out_read_data != '0)) |-> (o_out_status == ST_OK))
    `ILS_ASSERT_MSG(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_read_data) && $stable(o_out_status) && $stable(o_out_length)), "stalled result changed")

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_in_func       (i_in_func),
    .i_in_value      (i_in_value),
    .i_in_position   (i_in_position),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_read_data (o_out_read_data),
    .o_out_length    (o_out_length),
    .o_out_status    (o_out_status)
);

### bench/indexed_list_store_checker.sv
// Checker for the indexed list store: predicts every result and compares it.
`timescale 1ns / 100ps
module indexed_list_store_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [ils_pkg::FUNC_W-1:0]   i_in_func,
    input  logic [ils_pkg::VALUE_W-1:0]  i_in_value,
    input  logic [ils_pkg::POS_W-1:0]    i_in_position,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [ils_pkg::VALUE_W-1:0]  i_out_read_data,
    input  logic [ils_pkg::LEN_W-1:0]    i_out_length,
    input  logic [ils_pkg::STATUS_W-1:0] i_out_status,
    output int                           o_fail_count,
    output int                           o_pending
);
    import ils_pkg::*;

    localparam int EXP_DEPTH = 8;

    typedef struct packed {
        logic [VALUE_W-1:0] read_data;
        logic [LEN_W-1:0]   length;
        t_status            status;
    } t_list_result;

    logic [DATA_WIDTH-1:0] list_cells [CAPACITY];
    int unsigned           list_len;
    t_list_result          exp_fifo [EXP_DEPTH];
    int                    exp_head = 0;
    int                    exp_tail = 0;
    int                    exp_count = 0;
    int                    fail_count = 0;

    assign o_fail_count = fail_count;

    // Apply one request to the shadow list and return the result it should give.
    task automatic apply_request(input t_op op_in, input logic [VALUE_W-1:0] word,
                                 input logic [POS_W-1:0] index, output t_list_result res);
        t_op         op;
        int unsigned idx;
        op = op_in;
        idx = 32'(index);
        res.read_data = '0;
        res.status = ST_OK;
        // Insert at the end of the list is an append.
        if (op == OP_INSERT && idx == list_len) op = OP_APPEND;
        case (op)
            OP_APPEND: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_cells[list_len] = word[DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            OP_INSERT: begin
                // Range check wins over the full check.
                if (idx > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
                    list_cells[idx] = word[DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            OP_ERASE: begin
                if (idx >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = idx; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
                    list_len--;
                    list_cells[list_len] = '0;
                end
            end
            default: begin
                if (idx >= list_len) res.status = ST_RANGE;
                else res.read_data = list_cells[idx];
            end
        endcase
        res.length = list_len[LEN_W-1:0];
    endtask

    task automatic report_field(input string field, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] seen);
        fail_count++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, seen);
    endtask

    always @(posedge i_clk) begin
        t_list_result want_res;
        if (!i_rst_n) begin
            list_len = 0;
            exp_head = 0;
            exp_tail = 0;
            exp_count = 0;
            foreach (list_cells[i]) list_cells[i] = '0;
        end else begin
            // Check the result first: it always belongs to an earlier request.
            if (i_out_valid && !i_out_stall) begin
                if (exp_count == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual 0x%0h/%0d/%0d",
                             $time, i_out_read_data, i_out_length, i_out_status);
                end else begin
                    want_res = exp_fifo[exp_head];
                    exp_head = (exp_head + 1) % EXP_DEPTH;
                    exp_count--;
                    if (i_out_read_data !== want_res.read_data)
                        report_field("read_data", want_res.read_data, i_out_read_data);
                    if (i_out_length !== want_res.length)
                        report_field("length", VALUE_W'(want_res.length),
                                     VALUE_W'(i_out_length));
                    if (i_out_status !== want_res.status)
                        report_field("status", VALUE_W'(want_res.status),
                                     VALUE_W'(i_out_status));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request(t_op'(i_in_func), i_in_value, i_in_position, want_res);
                if (exp_count == EXP_DEPTH) begin
                    fail_count++;
                    $display("%0t: too many results outstanding, expected at most %0d, actual %0d",
                             $time, EXP_DEPTH, exp_count + 1);
                end else begin
                    exp_fifo[exp_tail] = want_res;
                    exp_tail = (exp_tail + 1) % EXP_DEPTH;
                    exp_count++;
                end
            end
        end
        o_pending <= exp_count;
    end

endmodule

### bench/indexed_list_store_tb.sv
// Top of the indexed list store testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module indexed_list_store_tb;
    import ils_pkg::*;

    localparam int RANDOM_REQUESTS = 1920;
    localparam int QUIET_TAIL      = 250;
    localparam int SEGMENT_LEN     = 100;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 4;

    // Direction the random requests push the list length in one segment.
    typedef enum int {FILL_GROW, FILL_SHRINK, FILL_MIXED} t_fill_trend;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [FUNC_W-1:0]     in_func = '0;
    logic [VALUE_W-1:0]    in_value = '0;
    logic [POS_W-1:0]      in_position = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [VALUE_W-1:0]    out_read_data;
    logic [LEN_W-1:0]      out_length;
    logic [STATUS_W-1:0]   out_status;

    int fail_count;
    int pending;

    // Stimulus bookkeeping: idle rates in percent and the length the list should have.
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int fill_level = 0;
    int full_hits = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int idle_cycles = 0;

    indexed_list_store DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_in_func       (in_func),
        .i_in_value      (in_value),
        .i_in_position   (in_position),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_out_read_data (out_read_data),
        .o_out_length    (out_length),
        .o_out_status    (out_status)
    );

    indexed_list_store_checker list_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_func       (in_func),
        .i_in_value      (in_value),
        .i_in_position   (in_position),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_read_data (out_read_data),
        .i_out_length    (out_length),
        .i_out_status    (out_status),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Stall the result side in random bursts; hold it low while idling is off.
    always @(posedge clk) begin
        if (!rst_n || stall_pct == 0) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one request, hold it until accepted, then maybe leave a gap.
    task automatic send_request(input t_op op, input logic [VALUE_W-1:0] word,
                                input logic [POS_W-1:0] index);
        int gap;
        in_valid <= 1'b1;
        in_func <= op;
        in_value <= word;
        in_position <= index;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // Track the length so that later positions can aim inside the list.
        op_count[int'(op)]++;
        case (op)
            OP_APPEND: begin
                if (fill_level < CAPACITY) fill_level++;
                else full_hits++;
            end
            OP_INSERT: begin
                if (index <= fill_level) begin
                    if (fill_level < CAPACITY) fill_level++;
                    else full_hits++;
                end
            end
            OP_ERASE: begin
                if (index < fill_level) fill_level--;
            end
            default: ;
        endcase
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
        end
    endtask

    initial begin
        t_op              op;
        logic [VALUE_W-1:0] word;
        logic [POS_W-1:0]   index;
        t_fill_trend      trend;
        int               roll;

        trend = FILL_MIXED;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 20;
        stall_pct = 20;

        // Directed: empty-list errors, then shifts, then the full-list cases.
        send_request(OP_READ, '0, 5'd31);          // read far out of range
        send_request(OP_ERASE, '0, 5'd0);          // erase on an empty list
        send_request(OP_INSERT, 32'h1234_5678, 5'd1); // insert past the end
        send_request(OP_INSERT, '1, 5'd0);         // insert at the end acts as append
        send_request(OP_INSERT, 32'hA5A5_A5A5, 5'd0); // insert in front, shift up
        send_request(OP_READ, '0, 5'd1);
        send_request(OP_ERASE, '0, 5'd0);          // erase in front, shift down
        send_request(OP_READ, '0, 5'd0);
        while (fill_level < CAPACITY - 1)
            send_request(OP_APPEND, $urandom, 5'($urandom_range(0, 31)));
        send_request(OP_INSERT, 32'h0000_0000, 5'd7);  // last free cell via a middle insert
        send_request(OP_APPEND, 32'hDEAD_BEEF, 5'd0);  // append on a full list
        send_request(OP_INSERT, 32'hCAFE_F00D, 5'd3);  // insert in range on a full list
        send_request(OP_INSERT, 32'h5555_AAAA, 5'd16); // insert at the end on a full list
        send_request(OP_INSERT, 32'hAAAA_5555, 5'd20); // range beats full
        send_request(OP_READ, '0, 5'd15);
        send_request(OP_ERASE, '0, 5'd15);

        // Random: segments that grow, shrink or churn the list under varying idling.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                trend = t_fill_trend'($urandom_range(0, 2));
                if (n >= RANDOM_REQUESTS - QUIET_TAIL) begin
                    gap_pct = 0;
                    stall_pct = 0;
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin gap_pct = 0; stall_pct = 0; end
                        1: begin gap_pct = 10; stall_pct = 10; end
                        2: begin gap_pct = 35; stall_pct = 5; end
                        default: begin gap_pct = 5; stall_pct = 40; end
                    endcase
                end
            end

            roll = $urandom_range(0, 99);
            case (trend)
                FILL_GROW: begin
                    if (roll < 45) op = OP_APPEND;
                    else if (roll < 80) op = OP_INSERT;
                    else if (roll < 90) op = OP_READ;
                    else op = OP_ERASE;
                end
                FILL_SHRINK: begin
                    if (roll < 45) op = OP_ERASE;
                    else if (roll < 75) op = OP_READ;
                    else if (roll < 90) op = OP_APPEND;
                    else op = OP_INSERT;
                end
                default: op = t_op'(roll % 4);
            endcase

            // Mostly aim inside the list; now and then anywhere in the field.
            if ($urandom_range(0, 99) < 12) index = POS_W'($urandom_range(0, 31));
            else if (op == OP_INSERT) index = POS_W'($urandom_range(0, fill_level));
            else if (fill_level > 0) index = POS_W'($urandom_range(0, fill_level - 1));
            else index = '0;

            case ($urandom_range(0, 9))
                0: word = '0;
                1: word = '1;
                default: word = $urandom;
            endcase

            send_request(op, word, index);
        end

        // Drain: drop valid, wait for the last result, then let the pipe settle.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d append, %0d insert, %0d erase, %0d read",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[int'(OP_APPEND)], op_count[int'(OP_INSERT)],
                 op_count[int'(OP_ERASE)], op_count[int'(OP_READ)]);
        $display("%0d requests hit a full list; %0d check failures",
                 full_hits, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ils_pkg.sv
rtl/core/ils_cell.sv
rtl/core/ils_row.sv
rtl/core/indexed_list_store.sv
rtl/core/ils_checker.sv
bench/indexed_list_store_checker.sv
bench/indexed_list_store_tb.sv
